@@ design/nbt_pkg.sv @@
package nbt_pkg;

    // Fixed field widths
    localparam int COORD_W  = 8;
    localparam int SERIAL_W = 16;
    localparam int VALUE_W  = 16;
    localparam int PORT_W   = 4;
    localparam int HOPS_W   = 4;
    localparam int DIST_W   = COORD_W + 1;

    // Number of physical ports; the mask is cut to the port field width
    localparam int PORT_COUNT = 4;
    localparam logic [PORT_W-1:0] ALL_PORTS = PORT_W'((2 ** PORT_COUNT) - 1);

    // Default table size
    localparam int TABLE_DEPTH_DEF = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOPS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_HEAD = 2'd2;

    // Operating modes
    localparam logic MODE_READ_ALL = 1'b0;
    localparam logic MODE_EVENT    = 1'b1;

    // Reset values of the configuration
    localparam logic [HOPS_W-1:0] MAX_HOPS_RST = 4'd2;
    localparam logic OP_MODE_RST      = MODE_EVENT;
    localparam logic CLUSTER_HEAD_RST = 1'b0;

    // One neighbor table entry
    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SERIAL_W-1:0] serial;
        logic [VALUE_W-1:0]  value;
        logic                updated;
    } entry_t;

    // Configuration seen by the controller
    typedef struct packed {
        logic [HOPS_W-1:0] max_hops;
        logic              op_mode;
        logic              cluster_head;
    } cfg_t;

    // |x| + |y| at full width, no wrap
    function automatic logic [DIST_W-1:0] hop_distance(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        begin
            ax = x[COORD_W-1] ? (~x + 1'b1) : x;
            ay = y[COORD_W-1] ? (~y + 1'b1) : y;
            hop_distance = {1'b0, ax} + {1'b0, ay};
        end
    endfunction

endpackage

@@ design/nbt_table.sv @@
module nbt_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    input  nbt_pkg::entry_t                wdata,
    input  logic                           re,
    input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output nbt_pkg::entry_t                rdata
);
    import nbt_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/nbt_ctrl.sv @@
module nbt_ctrl #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nbt_pkg::cfg_t                       cfg,
    // item side
    input  logic                                start,
    output logic                                busy,
    input  logic signed [nbt_pkg::COORD_W-1:0]  src_x,
    input  logic signed [nbt_pkg::COORD_W-1:0]  src_y,
    input  logic [nbt_pkg::SERIAL_W-1:0]        serial,
    input  logic [nbt_pkg::VALUE_W-1:0]         sensor_value,
    input  logic [nbt_pkg::PORT_W-1:0]          arrival_port,
    // result side
    output logic                                done,
    output logic                                accepted,
    output logic                                inserted,
    output logic [nbt_pkg::PORT_W-1:0]          forward_mask,
    output logic                                run_detection,
    output logic                                table_full,
    output logic [$clog2(TABLE_DEPTH)-1:0]      entry_index,
    // table memory
    output logic                                mem_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]      mem_waddr,
    output nbt_pkg::entry_t                     mem_wdata,
    output logic                                mem_re,
    output logic [$clog2(TABLE_DEPTH)-1:0]      mem_raddr,
    input  nbt_pkg::entry_t                     mem_rdata
);
    import nbt_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = AW + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched transaction
    logic [COORD_W-1:0]  x_reg, y_reg;
    logic [SERIAL_W-1:0] serial_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [PORT_W-1:0]   port_reg;

    // search state
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    logic [SERIAL_W-1:0] hit_serial_reg, hit_serial_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // result registers
    logic                done_reg, done_next;
    logic                acc_reg, acc_next;
    logic                ins_reg, ins_next;
    logic [PORT_W-1:0]   fwd_reg, fwd_next;
    logic                det_reg, det_next;
    logic                full_reg, full_next;
    logic [AW-1:0]       idx_reg, idx_next;

    logic                take;
    logic                match;
    logic                last;
    logic                fwd_ok;
    logic [PORT_W-1:0]   fwd_ports;

    assign busy = (state_reg != ST_IDLE);
    assign take = start && !busy;

    // compare of the entry read in the previous cycle
    assign match = (mem_rdata.x == x_reg) && (mem_rdata.y == y_reg);
    assign last  = ({1'b0, cmp_idx_reg} == (count_reg - 1'b1));

    // forwarding decision
    assign fwd_ok = (hop_distance(x_reg, y_reg) < {{(DIST_W-HOPS_W){1'b0}}, cfg.max_hops})
                 && ((cfg.op_mode == MODE_EVENT) || !cfg.cluster_head);
    assign fwd_ports = fwd_ok ? (ALL_PORTS & ~port_reg) : '0;

    // next-state and datapath
    always_comb
    begin
        state_next      = state_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_serial_next = hit_serial_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        acc_next        = acc_reg;
        ins_next        = ins_reg;
        fwd_next        = fwd_reg;
        det_next        = det_reg;
        full_next       = full_reg;
        idx_next        = idx_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '{x: x_reg, y: y_reg, serial: serial_reg,
                            value: value_reg, updated: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    found_next   = 1'b0;
                    cmp_idx_next = '0;
                    mem_re       = 1'b1;
                    if (count_reg == '0)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (match)
                begin
                    found_next      = 1'b1;
                    hit_idx_next    = cmp_idx_reg;
                    hit_serial_next = mem_rdata.serial;
                    state_next      = ST_DECIDE;
                end
                else if (last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    // fetch the next slot while this one is compared
                    mem_re       = 1'b1;
                    mem_raddr    = cmp_idx_reg + 1'b1;
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                end
            end

            ST_DECIDE:
            begin
                done_next  = 1'b1;
                acc_next   = 1'b0;
                ins_next   = 1'b0;
                fwd_next   = '0;
                det_next   = 1'b0;
                full_next  = 1'b0;
                idx_next   = '0;
                state_next = ST_IDLE;
                if (found_reg)
                begin
                    idx_next = hit_idx_reg;
                    if (hit_serial_reg != serial_reg)
                    begin
                        // refresh known source
                        mem_we            = 1'b1;
                        mem_waddr         = hit_idx_reg;
                        mem_wdata.updated = 1'b1;
                        acc_next          = 1'b1;
                        det_next          = 1'b1;
                        fwd_next          = fwd_ports;
                    end
                end
                else if (count_reg == CNT_FULL)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    // append new source
                    mem_we     = 1'b1;
                    mem_waddr  = count_reg[AW-1:0];
                    count_next = count_reg + 1'b1;
                    acc_next   = 1'b1;
                    ins_next   = 1'b1;
                    idx_next   = count_reg[AW-1:0];
                    fwd_next   = fwd_ports;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg      <= src_x;
            y_reg      <= src_y;
            serial_reg <= serial;
            value_reg  <= sensor_value;
            port_reg   <= arrival_port;
        end
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_serial_reg <= hit_serial_next;
        acc_reg        <= acc_next;
        ins_reg        <= ins_next;
        fwd_reg        <= fwd_next;
        det_reg        <= det_next;
        full_reg       <= full_next;
        idx_reg        <= idx_next;
    end

    assign done          = done_reg;
    assign accepted      = acc_reg;
    assign inserted      = ins_reg;
    assign forward_mask  = fwd_reg;
    assign run_detection = det_reg;
    assign table_full    = full_reg;
    assign entry_index   = idx_reg;

endmodule

@@ design/neighbor_table_dedup_forward.sv @@
// Channel   Signals                                        Handshake
// -------   --------------------------------------------   -----------------------------
// item      src_x src_y serial sensor_value arrival_port   taken when start && !busy
// result    accepted inserted forward_mask run_detection   one-cycle strobe on done
//           table_full entry_index
// config    cfg_we cfg_index cfg_data                      written when cfg_we is high
//
// A transaction goes from acceptance through the search state (skipped on an empty table)
// and the decide state to the done strobe, searching at most TABLE_DEPTH neighbors:
// the coordinate search reads one table slot per cycle from the single memory read port.
// Results hold from done until the next decision; busy is low again in the done cycle.
// rst_n clears the table (entry count to zero) and loads config reset values; the result
// side cannot stall. The user must write configuration only while busy is low (unchecked).
module neighbor_table_dedup_forward #(
    parameter int TABLE_DEPTH = nbt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [nbt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nbt_pkg::HOPS_W-1:0]           cfg_data,
    // item
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [nbt_pkg::COORD_W-1:0]   src_x,
    input  logic signed [nbt_pkg::COORD_W-1:0]   src_y,
    input  logic [nbt_pkg::SERIAL_W-1:0]         serial,
    input  logic [nbt_pkg::VALUE_W-1:0]          sensor_value,
    input  logic [nbt_pkg::PORT_W-1:0]           arrival_port,
    // result
    output logic                                 done,
    output logic                                 accepted,
    output logic                                 inserted,
    output logic [nbt_pkg::PORT_W-1:0]           forward_mask,
    output logic                                 run_detection,
    output logic                                 table_full,
    output logic [$clog2(TABLE_DEPTH)-1:0]       entry_index
);
    import nbt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    cfg_t   cfg_reg;
    logic   mem_we;
    logic   mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t mem_wdata;
    entry_t mem_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_hops     <= MAX_HOPS_RST;
            cfg_reg.op_mode      <= OP_MODE_RST;
            cfg_reg.cluster_head <= CLUSTER_HEAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_HOPS:     cfg_reg.max_hops     <= cfg_data;
                REG_OP_MODE:      cfg_reg.op_mode      <= cfg_data[0];
                REG_CLUSTER_HEAD: cfg_reg.cluster_head <= cfg_data[0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    nbt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .start         (start),
        .busy          (busy),
        .src_x         (src_x),
        .src_y         (src_y),
        .serial        (serial),
        .sensor_value  (sensor_value),
        .arrival_port  (arrival_port),
        .done          (done),
        .accepted      (accepted),
        .inserted      (inserted),
        .forward_mask  (forward_mask),
        .run_detection (run_detection),
        .table_full    (table_full),
        .entry_index   (entry_index),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    nbt_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
